>>> rtl/core/psa_pkg.sv
package psa_pkg;

  // Pool sizes, laid end to end in one global slot space
  localparam int unsigned POOL0_SLOTS = 3;
  localparam int unsigned POOL1_SLOTS = 25;
  localparam int unsigned POOL2_SLOTS = 3;
  localparam int unsigned POOL3_SLOTS = 15;

  localparam int unsigned POOL1_BASE  = POOL0_SLOTS;
  localparam int unsigned POOL2_BASE  = POOL0_SLOTS + POOL1_SLOTS;
  localparam int unsigned POOL3_BASE  = POOL0_SLOTS + POOL1_SLOTS + POOL2_SLOTS;
  localparam int unsigned TOTAL_SLOTS = POOL3_BASE + POOL3_SLOTS;

  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned ADDR_W   = $clog2(TOTAL_SLOTS);
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned RANGE_W  = 8;

  localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(TOTAL_SLOTS);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC       = 2'd0,
    ACT_RELEASE     = 2'd1,
    ACT_QUERY       = 2'd2,
    ACT_RELEASE_ALL = 2'd3
  } action_e;

  localparam logic [KIND_W-1:0] KIND_POOL0  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POOL1A = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POOL1B = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POOL2  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POOL3  = 3'd4;

  typedef struct packed {
    action_e             action;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    tag_first;
    logic [TAG_W-1:0]    tag_second;
    logic                frozen;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [ADDR_W-1:0]   idx;
  } find_t;

  typedef struct packed {
    logic                known;
    logic [RANGE_W-1:0]  base;
    logic [RANGE_W-1:0]  size;
  } pool_t;

  function automatic pool_t pool_of_kind(input logic [KIND_W-1:0] kind);
    pool_t p;
    p.known = 1'b1;
    p.base  = '0;
    p.size  = '0;
    case (kind)
      KIND_POOL0: begin
        p.size = RANGE_W'(POOL0_SLOTS);
      end
      KIND_POOL1A, KIND_POOL1B: begin
        p.base = RANGE_W'(POOL1_BASE);
        p.size = RANGE_W'(POOL1_SLOTS);
      end
      KIND_POOL2: begin
        p.base = RANGE_W'(POOL2_BASE);
        p.size = RANGE_W'(POOL2_SLOTS);
      end
      KIND_POOL3: begin
        p.base = RANGE_W'(POOL3_BASE);
        p.size = RANGE_W'(POOL3_SLOTS);
      end
      default: begin
        p.known = 1'b0;
      end
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/partitioned_slot_allocator_unit.sv
// A request accepted in idle is registered and commits in the exec state once the output
// register is free or draining; the result is registered. No new request is taken until
//   then: the request register and the tag memory's registered read port (read at accept, used at commit) lie between.
// A result waiting in the output register does not block the next request's accept.
// Reset clears every active flag and all control state; tag memory contents stay
//   undefined until an allocate writes them, and no clearing pass is needed.
module partitioned_slot_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] slot_in, [13:6] tag_first, [21:14] tag_second, [22] frozen, [23] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] action, [4:2] kind, [7:5] zero
  input  logic [7:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] granted, [6:1] slot_out, [7] slot_active, [15:8] tag_first_out,
  // [23:16] tag_second_out
  output logic [23:0] m_axis_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  localparam int unsigned TAGS_W = 2 * psa_pkg::TAG_W;

  logic                            state_q, state_d;
  psa_pkg::req_t                   req_q, req_in;
  logic [psa_pkg::TOTAL_SLOTS-1:0] active_q, active_d;
  logic                            m_valid_q, m_valid_d;
  logic [23:0]                     m_data_q, m_data_d;

  logic                            accept;
  logic                            commit;
  logic                            slot_in_range;
  logic                            slot_is_active;
  logic                            ram_re;
  logic                            ram_we;
  logic [TAGS_W-1:0]               ram_rdata;
  psa_pkg::find_t                  find;

  // Unpack the incoming request
  assign req_in.action     = psa_pkg::action_e'(s_axis_tuser[1:0]);
  assign req_in.kind       = s_axis_tuser[4:2];
  assign req_in.slot       = s_axis_tdata[5:0];
  assign req_in.tag_first  = s_axis_tdata[13:6];
  assign req_in.tag_second = s_axis_tdata[21:14];
  assign req_in.frozen     = s_axis_tdata[22];

  // Accept in idle, regardless of whether the previous result was taken yet
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Commit once the output register is free or is being drained this cycle
  assign commit = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

  // Tag read for a query launches at accept; data is ready in the exec cycle
  // and holds there while the output stalls.
  assign ram_re = accept && (req_in.action == psa_pkg::ACT_QUERY)
                  && (req_in.slot < psa_pkg::NONE_SLOT);

  assign ram_we = commit && (req_q.action == psa_pkg::ACT_ALLOC) && find.found;

  psa_ram #(
    .WIDTH (TAGS_W),
    .DEPTH (psa_pkg::TOTAL_SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (find.idx),
    .wdata_i ({req_q.tag_second, req_q.tag_first}),
    .re_i    (ram_re),
    .raddr_i (req_in.slot[psa_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  psa_free_find u_free_find (
    .active_i (active_q),
    .kind_i   (req_q.kind),
    .frozen_i (req_q.frozen),
    .find_o   (find)
  );

  assign slot_in_range  = (req_q.slot < psa_pkg::NONE_SLOT);
  assign slot_is_active = slot_in_range && active_q[req_q.slot[psa_pkg::ADDR_W-1:0]];

  // Next state, active map update and result formation
  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
          m_data_d  = '0;
          case (req_q.action)
            psa_pkg::ACT_ALLOC: begin
              if (find.found) begin
                active_d[find.idx] = 1'b1;
                m_data_d[0]        = 1'b1;
                m_data_d[6:1]      = psa_pkg::SLOT_W'(find.idx);
              end else begin
                m_data_d[6:1]      = psa_pkg::NONE_SLOT;
              end
            end
            psa_pkg::ACT_RELEASE: begin
              if (slot_in_range) begin
                active_d[req_q.slot[psa_pkg::ADDR_W-1:0]] = 1'b0;
              end
              m_data_d[6:1] = req_q.slot;
            end
            psa_pkg::ACT_QUERY: begin
              m_data_d[6:1] = req_q.slot;
              if (slot_is_active) begin
                m_data_d[7]     = 1'b1;
                m_data_d[23:8]  = ram_rdata;
              end
            end
            psa_pkg::ACT_RELEASE_ALL: begin
              active_d      = '0;
              m_data_d[6:1] = psa_pkg::NONE_SLOT;
            end
            default: begin
              m_data_d[6:1] = psa_pkg::NONE_SLOT;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_in;
    end
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/core/psa_ram.sv
module psa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 46
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/psa_free_find.sv
module psa_free_find (
  input  logic [psa_pkg::TOTAL_SLOTS-1:0] active_i,
  input  logic [psa_pkg::KIND_W-1:0]      kind_i,
  input  logic                            frozen_i,
  output psa_pkg::find_t                  find_o
);

  psa_pkg::pool_t                  pool;
  logic [psa_pkg::TOTAL_SLOTS-1:0] free_in_pool;

  assign pool = psa_pkg::pool_of_kind(kind_i);

  // Mark free slots that fall inside the selected pool
  always_comb begin
    for (int g = 0; g < int'(psa_pkg::TOTAL_SLOTS); g++) begin
      free_in_pool[g] = !active_i[g]
                        && (g >= int'(pool.base))
                        && (g < int'(pool.base) + int'(pool.size));
    end
  end

  // Lowest free slot wins: scan down so the lowest index is written last
  always_comb begin
    find_o.found = pool.known && !frozen_i && (|free_in_pool);
    find_o.idx   = '0;
    for (int g = int'(psa_pkg::TOTAL_SLOTS) - 1; g >= 0; g--) begin
      if (free_in_pool[g]) begin
        find_o.idx = psa_pkg::ADDR_W'(g);
      end
    end
  end

endmodule

>>> rtl/core/psa_checker.sv
module psa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A granted slot is always a real slot and never reports query fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      (m_axis_tdata[6:1] < psa_pkg::NONE_SLOT) && !m_axis_tdata[7])
    else $error("granted request carries bad slot or active flag");

  // Inactive query results never leak tag bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[7] |-> (m_axis_tdata[23:8] == 16'd0))
    else $error("tags reported for an inactive slot");

  // One request at a time: the input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one still executing");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under backpressure");

endmodule

bind partitioned_slot_allocator_unit psa_checker u_psa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/tb_partitioned_slot_allocator_unit.sv
module tb_partitioned_slot_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Kinds outside the four pools; an allocate with one of these must fail
  localparam logic [psa_pkg::KIND_W-1:0] KIND_BAD_LO  = 3'd5;
  localparam logic [psa_pkg::KIND_W-1:0] KIND_BAD_MID = 3'd6;
  localparam logic [psa_pkg::KIND_W-1:0] KIND_BAD_HI  = 3'd7;

  localparam int RANDOM_REQUESTS = 1925;
  localparam int HOLD_CYCLES     = 200;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 8;

  // One result as it leaves the block
  typedef struct packed {
    logic                       granted;
    logic [psa_pkg::SLOT_W-1:0] slot;
    logic                       active;
    logic [psa_pkg::TAG_W-1:0]  tag_first;
    logic [psa_pkg::TAG_W-1:0]  tag_second;
  } rsp_t;

  // One row of the directed table; fixed rows carry the result typed in
  typedef struct {
    psa_pkg::req_t req;
    logic          fixed;
    rsp_t          res;
  } dir_row_t;

  // Per offered request: a typed result, or none to take the predicted one
  typedef struct {
    logic fixed;
    rsp_t res;
  } plan_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [5:0] slot_in, [13:6] tag_first, [21:14] tag_second, [22] frozen, [23] zero
  logic [23:0] s_axis_tdata  = '0;
  // [1:0] action, [4:2] kind, [7:5] zero
  logic [7:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] granted, [6:1] slot_out, [7] slot_active, [15:8] tag_first_out,
  // [23:16] tag_second_out
  logic [23:0] m_axis_tdata;

  partitioned_slot_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the slot table, advanced once per accepted request
  logic                      slot_busy [psa_pkg::TOTAL_SLOTS];
  logic [psa_pkg::TAG_W-1:0] slot_tag1 [psa_pkg::TOTAL_SLOTS];
  logic [psa_pkg::TAG_W-1:0] slot_tag2 [psa_pkg::TOTAL_SLOTS];

  rsp_t     pending_results [$];
  plan_t    stim_plan [$];
  dir_row_t dir_rows [$];

  bit idle_en   = 1'b1;
  bit hold_sink = 1'b0;

  int n_errors       = 0;
  int n_requests     = 0;
  int n_results      = 0;
  int n_grants       = 0;
  int n_refused      = 0;
  int n_live_queries = 0;
  int n_clears       = 0;
  int n_cycles       = 0;

  initial begin
    for (int i = 0; i < psa_pkg::TOTAL_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_tag1[i] = '0;
      slot_tag2[i] = '0;
    end
  end

  // Apply one request to the shadow table and return the result it must produce
  function automatic rsp_t slot_table_step(psa_pkg::req_t r);
    rsp_t o;
    int   base;
    int   size;
    bit   known;
    bit   found;
    o = '0;
    case (r.action)
      psa_pkg::ACT_ALLOC: begin
        o.slot = psa_pkg::NONE_SLOT;
        known  = 1'b1;
        found  = 1'b0;
        base   = 0;
        size   = 0;
        case (r.kind)
          psa_pkg::KIND_POOL0: begin
            size = psa_pkg::POOL0_SLOTS;
          end
          psa_pkg::KIND_POOL1A, psa_pkg::KIND_POOL1B: begin
            base = psa_pkg::POOL1_BASE;
            size = psa_pkg::POOL1_SLOTS;
          end
          psa_pkg::KIND_POOL2: begin
            base = psa_pkg::POOL2_BASE;
            size = psa_pkg::POOL2_SLOTS;
          end
          psa_pkg::KIND_POOL3: begin
            base = psa_pkg::POOL3_BASE;
            size = psa_pkg::POOL3_SLOTS;
          end
          default: begin
            known = 1'b0;
          end
        endcase
        // Lowest free slot of the pool wins
        if (!r.frozen && known) begin
          for (int i = 0; i < size; i++) begin
            if (!found && !slot_busy[base + i]) begin
              found                = 1'b1;
              slot_busy[base + i]  = 1'b1;
              slot_tag1[base + i]  = r.tag_first;
              slot_tag2[base + i]  = r.tag_second;
              o.granted            = 1'b1;
              o.slot               = psa_pkg::SLOT_W'(base + i);
            end
          end
        end
      end
      psa_pkg::ACT_RELEASE: begin
        o.slot = r.slot;
        if (r.slot < psa_pkg::NONE_SLOT) slot_busy[r.slot] = 1'b0;
      end
      psa_pkg::ACT_QUERY: begin
        o.slot = r.slot;
        if (r.slot < psa_pkg::NONE_SLOT && slot_busy[r.slot]) begin
          o.active     = 1'b1;
          o.tag_first  = slot_tag1[r.slot];
          o.tag_second = slot_tag2[r.slot];
        end
      end
      default: begin
        for (int i = 0; i < psa_pkg::TOTAL_SLOTS; i++) slot_busy[i] = 1'b0;
        o.slot = psa_pkg::NONE_SLOT;
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d, want %0d", n_results, what, got, want);
    n_errors++;
  endtask

  // Requests and results are both sampled here, before this edge's updates land
  always @(posedge clk_i) begin
    rsp_t          want;
    rsp_t          got;
    psa_pkg::req_t r;
    plan_t         p;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r.action     = psa_pkg::action_e'(s_axis_tuser[1:0]);
      r.kind       = s_axis_tuser[4:2];
      r.slot       = s_axis_tdata[5:0];
      r.tag_first  = s_axis_tdata[13:6];
      r.tag_second = s_axis_tdata[21:14];
      r.frozen     = s_axis_tdata[22];
      want = slot_table_step(r);
      p = stim_plan.pop_front();
      if (p.fixed) want = p.res;
      if (r.action == psa_pkg::ACT_ALLOC) begin
        if (want.granted) n_grants++;
        else n_refused++;
      end
      if (r.action == psa_pkg::ACT_QUERY && want.active) n_live_queries++;
      if (r.action == psa_pkg::ACT_RELEASE_ALL) n_clears++;
      pending_results.push_back(want);
      n_requests++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.granted    = m_axis_tdata[0];
      got.slot       = m_axis_tdata[6:1];
      got.active     = m_axis_tdata[7];
      got.tag_first  = m_axis_tdata[15:8];
      got.tag_second = m_axis_tdata[23:16];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.granted !== want.granted)
          report_mismatch("granted", int'(got.granted), int'(want.granted));
        if (got.slot !== want.slot)
          report_mismatch("slot_out", int'(got.slot), int'(want.slot));
        if (got.active !== want.active)
          report_mismatch("slot_active", int'(got.active), int'(want.active));
        if (got.tag_first !== want.tag_first)
          report_mismatch("tag_first_out", int'(got.tag_first), int'(want.tag_first));
        if (got.tag_second !== want.tag_second)
          report_mismatch("tag_second_out", int'(got.tag_second), int'(want.tag_second));
      end
      n_results++;
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", n_cycles,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_sink = 1'b0;
      end else begin
        m_axis_tready <= !(idle_en && $urandom_range(99) < 36);
      end
    end
  end

  // Offer one request, with a random gap ahead of it; return at its accept edge
  task automatic send_request(psa_pkg::req_t r);
    while (idle_en && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.frozen, r.tag_second, r.tag_first, r.slot};
    s_axis_tuser  <= {3'b000, r.kind, r.action};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic dir_row_t dir_row(psa_pkg::action_e a,
                                       logic [psa_pkg::KIND_W-1:0] k,
                                       logic [psa_pkg::SLOT_W-1:0] s,
                                       logic [psa_pkg::TAG_W-1:0] t1,
                                       logic [psa_pkg::TAG_W-1:0] t2, logic fz, logic fx,
                                       logic g, logic [psa_pkg::SLOT_W-1:0] so);
    dir_row_t d;
    d.req.action     = a;
    d.req.kind       = k;
    d.req.slot       = s;
    d.req.tag_first  = t1;
    d.req.tag_second = t2;
    d.req.frozen     = fz;
    d.fixed          = fx;
    d.res            = '0;
    d.res.granted    = g;
    d.res.slot       = so;
    return d;
  endfunction

  // Allocates most often, with live releases and queries mixed in, so pools fill,
  // overflow and churn; a little noise in kind, slot and freeze
  function automatic psa_pkg::req_t random_request();
    psa_pkg::req_t r;
    int            live [$];
    int            pick;
    for (int i = 0; i < psa_pkg::TOTAL_SLOTS; i++) if (slot_busy[i]) live.push_back(i);
    r.tag_first  = psa_pkg::TAG_W'($urandom_range(255));
    r.tag_second = psa_pkg::TAG_W'($urandom_range(255));
    r.frozen     = ($urandom_range(99) < 5);
    if ($urandom_range(99) < 90)
      r.kind = psa_pkg::KIND_W'($urandom_range(int'(psa_pkg::KIND_POOL3)));
    else
      r.kind = psa_pkg::KIND_W'($urandom_range(int'(KIND_BAD_LO), int'(KIND_BAD_HI)));
    if ($urandom_range(99) < 85)
      r.slot = psa_pkg::SLOT_W'($urandom_range(psa_pkg::TOTAL_SLOTS - 1));
    else
      r.slot = psa_pkg::SLOT_W'($urandom_range(psa_pkg::TOTAL_SLOTS, 63));
    pick = $urandom_range(99);
    if (pick < 48) begin
      r.action = psa_pkg::ACT_ALLOC;
    end else if (pick < 73) begin
      r.action = psa_pkg::ACT_RELEASE;
      if (live.size() != 0 && $urandom_range(99) < 70)
        r.slot = psa_pkg::SLOT_W'(live[$urandom_range(live.size() - 1)]);
    end else if (pick < 98) begin
      r.action = psa_pkg::ACT_QUERY;
      if (live.size() != 0 && $urandom_range(99) < 60)
        r.slot = psa_pkg::SLOT_W'(live[$urandom_range(live.size() - 1)]);
    end else begin
      r.action = psa_pkg::ACT_RELEASE_ALL;
    end
    return r;
  endfunction

  initial begin
    plan_t p;
    // Directed requests; rows with a typed result follow straight from reset
    // state, the rest lean on the shadow table
    dir_rows.push_back(dir_row(psa_pkg::ACT_QUERY, psa_pkg::KIND_POOL0, 6'd0, 8'h00, 8'h00,
                               0, 1, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL0, 6'd0, 8'hFF, 8'h00,
                               0, 1, 1, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL0, 6'd0, 8'h12, 8'h34,
                               1, 1, 0, psa_pkg::NONE_SLOT));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, KIND_BAD_LO, 6'd0, 8'h01, 8'h02,
                               0, 1, 0, psa_pkg::NONE_SLOT));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, KIND_BAD_MID, 6'd0, 8'h03, 8'h04,
                               0, 1, 0, psa_pkg::NONE_SLOT));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, KIND_BAD_HI, 6'h3F, 8'hFF, 8'hFF,
                               0, 1, 0, psa_pkg::NONE_SLOT));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL1A, 6'd0, 8'h00, 8'hFF,
                               0, 1, 1, psa_pkg::SLOT_W'(psa_pkg::POOL1_BASE)));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL1B, 6'd0, 8'hA5, 8'h5A,
                               0, 1, 1, psa_pkg::SLOT_W'(psa_pkg::POOL1_BASE + 1)));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL2, 6'd0, 8'h5A, 8'hA5,
                               0, 1, 1, psa_pkg::SLOT_W'(psa_pkg::POOL2_BASE)));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL3, 6'd0, 8'h80, 8'h01,
                               0, 1, 1, psa_pkg::SLOT_W'(psa_pkg::POOL3_BASE)));
    // Fill pool 0, then one more allocate finds it full
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL0, 6'd0, 8'h11, 8'h22,
                               0, 0, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL0, 6'd0, 8'h33, 8'h44,
                               0, 0, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL0, 6'd0, 8'h55, 8'h66,
                               0, 0, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_QUERY, psa_pkg::KIND_POOL0, 6'd0, 8'h00, 8'h00,
                               0, 0, 0, 6'd0));
    // Out-of-range and none indices for query and release
    dir_rows.push_back(dir_row(psa_pkg::ACT_QUERY, psa_pkg::KIND_POOL0, 6'h3F, 8'h00, 8'h00,
                               0, 1, 0, 6'h3F));
    dir_rows.push_back(dir_row(psa_pkg::ACT_QUERY, psa_pkg::KIND_POOL0, psa_pkg::NONE_SLOT,
                               8'h00, 8'h00, 0, 1, 0, psa_pkg::NONE_SLOT));
    dir_rows.push_back(dir_row(psa_pkg::ACT_RELEASE, psa_pkg::KIND_POOL0, 6'h3F, 8'h00,
                               8'h00, 0, 1, 0, 6'h3F));
    dir_rows.push_back(dir_row(psa_pkg::ACT_RELEASE, psa_pkg::KIND_POOL0, psa_pkg::NONE_SLOT,
                               8'h00, 8'h00, 0, 1, 0, psa_pkg::NONE_SLOT));
    // Release a live slot, release it again while free, then reclaim it
    dir_rows.push_back(dir_row(psa_pkg::ACT_RELEASE, psa_pkg::KIND_POOL0, 6'd1, 8'h00,
                               8'h00, 0, 0, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_RELEASE, psa_pkg::KIND_POOL0, 6'd1, 8'h00,
                               8'h00, 0, 0, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_QUERY, psa_pkg::KIND_POOL0, 6'd1, 8'h00, 8'h00,
                               0, 0, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL0, 6'd0, 8'h77, 8'h88,
                               0, 0, 0, 6'd0));
    dir_rows.push_back(dir_row(psa_pkg::ACT_ALLOC, psa_pkg::KIND_POOL3, 6'h3F, 8'hFF, 8'hFF,
                               1, 1, 0, psa_pkg::NONE_SLOT));
    dir_rows.push_back(dir_row(psa_pkg::ACT_RELEASE_ALL, psa_pkg::KIND_POOL0, 6'd0,
                               8'h00, 8'h00, 0, 1, 0, psa_pkg::NONE_SLOT));
    dir_rows.push_back(dir_row(psa_pkg::ACT_QUERY, psa_pkg::KIND_POOL0,
                               psa_pkg::SLOT_W'(psa_pkg::POOL1_BASE), 8'h00, 8'h00,
                               0, 1, 0, psa_pkg::SLOT_W'(psa_pkg::POOL1_BASE)));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      p.fixed = dir_rows[i].fixed;
      p.res   = dir_rows[i].res;
      stim_plan.push_back(p);
      send_request(dir_rows[i].req);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Stall the receiver for a long stretch while requests keep coming
      if (n == 400) hold_sink = 1'b1;
      // Back-to-back traffic on both sides for a while
      idle_en = !(n >= 900 && n < 1300);
      // Pause until the block has handed back everything it owes
      if (n == 1500) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      p.fixed = 1'b0;
      p.res   = '0;
      stim_plan.push_back(p);
      send_request(random_request());
    end

    // Drain, then give the block a settle period to show any stray result
    s_axis_tvalid <= 1'b0;
    idle_en = 1'b1;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d grants, %0d refused allocates, %0d live queries,",
             n_requests, n_grants, n_refused, n_live_queries);
    $display("%0d release-all requests, %0d results checked, %0d mismatches",
             n_clears, n_results, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
